>>> hdl/fixed_chunk_pool_allocator_macros.svh
// Assertion macros for the chunk pool allocator RTL.
`ifndef FIXED_CHUNK_POOL_ALLOCATOR_MACROS_SVH
`define FIXED_CHUNK_POOL_ALLOCATOR_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define FCPA_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define FCPA_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/fcpa_pkg.sv
// Types and constants of the fixed chunk pool allocator.
`default_nettype none

package fcpa_pkg;

    // Default sizing
    localparam int NUM_CHUNKS_DEF = 64;
    localparam int ADDR_BITS_DEF  = 32;

    // Fixed field widths
    localparam int ADDR_W  = 32;
    localparam int BYTES_W = 16;
    localparam int CMD_W   = 2;
    localparam int STAT_W  = 2;

    // Configuration port
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_ADDRESS = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_CHUNK_BYTES  = CFG_IDX_W'(1);

    // Register reset values
    localparam logic [ADDR_W-1:0]  BASE_ADDRESS_RST = '0;
    localparam logic [BYTES_W-1:0] CHUNK_BYTES_RST  = BYTES_W'(64);

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC = 2'd0,
        CMD_FREE  = 2'd1,
        CMD_RESET = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_EMPTY     = 2'd1,
        STAT_TOO_LARGE = 2'd2,
        STAT_FULL      = 2'd3
    } status_t;

    typedef enum logic {
        ST_FILL = 1'b0,
        ST_RUN  = 1'b1
    } state_t;

    // Shift command for the row of stack cells
    typedef struct packed {
        logic push;
        logic pop;
    } stack_op_t;

endpackage

`default_nettype wire

>>> hdl/fixed_chunk_pool_allocator.sv
// Top level of the fixed chunk pool allocator: control, accounting, result register.
//
// Usage:
//   Requests enter on s_valid/s_ready with s_command (allocate, free, reset
//   pool), s_request_bytes and s_release_address. Each request gives exactly
//   one result on m_valid/m_ready: m_chunk_address, m_status, m_bytes_in_use
//   and m_peak_bytes. Allocate and free touch only the stack top, so they
//   sustain one request per clock while m_ready keeps the result register
//   free and no refill runs; the result shows the cycle after acceptance.
//   A reset-pool request refills the cell row with ascending chunk addresses
//   before its result shows; no request is taken meanwhile. Register
//   writes on cfg_valid/cfg_ready are always accepted and apply to
//   allocations at once and to the stack at the next pool reset.
//   After aresetn the registers return to base 0 and chunk size 64 and the
//   same refill runs, with s_ready low, before the first request is taken.
//   The result register keeps a result while m_ready is low; a new request
//   is taken only when that register is empty or being emptied.
`default_nettype none

module fixed_chunk_pool_allocator #(
    parameter int NUM_CHUNKS = fcpa_pkg::NUM_CHUNKS_DEF,
    parameter int ADDR_BITS  = fcpa_pkg::ADDR_BITS_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,

    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [fcpa_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [fcpa_pkg::CFG_DATA_W-1:0] cfg_data,

    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic [fcpa_pkg::CMD_W-1:0]      s_command,
    input  wire logic [fcpa_pkg::BYTES_W-1:0]    s_request_bytes,
    input  wire logic [fcpa_pkg::ADDR_W-1:0]     s_release_address,

    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic      [fcpa_pkg::ADDR_W-1:0]     m_chunk_address,
    output logic      [fcpa_pkg::STAT_W-1:0]     m_status,
    output logic      [fcpa_pkg::ADDR_W-1:0]     m_bytes_in_use,
    output logic      [fcpa_pkg::ADDR_W-1:0]     m_peak_bytes
);

    `include "fixed_chunk_pool_allocator_macros.svh"

    localparam int AW     = fcpa_pkg::ADDR_W;
    localparam int BW     = fcpa_pkg::BYTES_W;
    localparam int CELL_W = (ADDR_BITS < AW) ? ADDR_BITS : AW;
    localparam int SUM_W  = (CELL_W > BW) ? CELL_W : BW;
    localparam int CNT_W  = $clog2(NUM_CHUNKS + 1);
    localparam int FILL_W = (NUM_CHUNKS > 1) ? $clog2(NUM_CHUNKS) : 1;
    localparam logic [CNT_W-1:0]  CNT_FULL  = CNT_W'(NUM_CHUNKS);
    localparam logic [FILL_W-1:0] FILL_LAST = FILL_W'(NUM_CHUNKS - 1);

    // Registers
    fcpa_pkg::state_t  state_reg, state_next;
    logic [AW-1:0]     base_address_reg;
    logic [BW-1:0]     chunk_bytes_reg;
    logic [CELL_W-1:0] fill_addr_reg, fill_addr_next;
    logic [BW-1:0]     fill_step_reg, fill_step_next;
    logic [FILL_W-1:0] fill_cnt_reg, fill_cnt_next;
    logic              pend_reply_reg, pend_reply_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [AW-1:0]     used_reg, used_next;
    logic [AW-1:0]     peak_reg, peak_next;
    logic              out_valid_reg, out_valid_next;
    logic [AW-1:0]     out_addr_reg, out_addr_next;
    logic [fcpa_pkg::STAT_W-1:0] out_stat_reg, out_stat_next;
    logic [AW-1:0]     out_used_reg, out_used_next;
    logic [AW-1:0]     out_peak_reg, out_peak_next;

    // Stack interface and helpers
    fcpa_pkg::stack_op_t stack_op;
    logic [CELL_W-1:0]   push_data;
    logic [CELL_W-1:0]   top_data;
    logic                accept;
    logic                out_free;
    logic [AW:0]         used_add;
    logic [AW-1:0]       used_inc;
    logic [AW-1:0]       used_dec;
    logic [SUM_W-1:0]    fill_sum;
    logic [AW-1:0]       peak_cand;

    // Free-address stack
    fcpa_stack #(
        .DEPTH (NUM_CHUNKS),
        .DATA_W(CELL_W)
    ) u_stack (
        .aclk     (aclk),
        .op       (stack_op),
        .push_data(push_data),
        .top_data (top_data)
    );

    // Configuration registers, always writable
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_address_reg <= fcpa_pkg::BASE_ADDRESS_RST;
            chunk_bytes_reg  <= fcpa_pkg::CHUNK_BYTES_RST;
        end else if (cfg_valid) begin
            if (cfg_index == fcpa_pkg::REG_BASE_ADDRESS) begin
                base_address_reg <= cfg_data[AW-1:0];
            end else if (cfg_index == fcpa_pkg::REG_CHUNK_BYTES) begin
                chunk_bytes_reg <= cfg_data[BW-1:0];
            end
        end
    end

    // Handshake
    assign out_free = !out_valid_reg || m_ready;
    assign s_ready  = (state_reg == fcpa_pkg::ST_RUN) && out_free;
    assign accept   = s_valid && s_ready;

    // Byte accounting, saturating both ways
    assign used_add = {1'b0, used_reg} + (AW + 1)'(chunk_bytes_reg);
    assign used_inc = used_add[AW] ? '1 : used_add[AW-1:0];
    assign used_dec = (used_reg >= AW'(chunk_bytes_reg)) ?
                      (used_reg - AW'(chunk_bytes_reg)) : '0;
    assign fill_sum = SUM_W'(fill_addr_reg) + SUM_W'(fill_step_reg);
    assign peak_cand = (used_inc > peak_reg) ? used_inc : peak_reg;

    // Next state, stack shifts and result
    always_comb begin
        state_next      = state_reg;
        fill_addr_next  = fill_addr_reg;
        fill_step_next  = fill_step_reg;
        fill_cnt_next   = fill_cnt_reg;
        pend_reply_next = pend_reply_reg;
        count_next      = count_reg;
        used_next       = used_reg;
        peak_next       = peak_reg;
        out_valid_next  = out_valid_reg && !m_ready;
        out_addr_next   = out_addr_reg;
        out_stat_next   = out_stat_reg;
        out_used_next   = out_used_reg;
        out_peak_next   = out_peak_reg;
        stack_op        = '0;
        push_data       = fill_addr_reg;

        case (state_reg)
            fcpa_pkg::ST_FILL: begin
                // push ascending addresses, the last one ends on top
                stack_op.push  = 1'b1;
                fill_addr_next = fill_sum[CELL_W-1:0];
                fill_cnt_next  = fill_cnt_reg + FILL_W'(1);
                if (fill_cnt_reg == FILL_LAST) begin
                    state_next      = fcpa_pkg::ST_RUN;
                    count_next      = CNT_FULL;
                    pend_reply_next = 1'b0;
                    if (pend_reply_reg) begin
                        out_valid_next = 1'b1;
                        out_addr_next  = '0;
                        out_stat_next  = fcpa_pkg::STAT_OK;
                        out_used_next  = '0;
                        out_peak_next  = '0;
                    end
                end
            end
            fcpa_pkg::ST_RUN: begin
                if (accept) begin
                    out_valid_next = 1'b1;
                    out_addr_next  = '0;
                    out_stat_next  = fcpa_pkg::STAT_OK;
                    case (fcpa_pkg::cmd_t'(s_command))
                        fcpa_pkg::CMD_ALLOC: begin
                            if (s_request_bytes > chunk_bytes_reg) begin
                                out_stat_next = fcpa_pkg::STAT_TOO_LARGE;
                            end else if (count_reg == '0) begin
                                out_stat_next = fcpa_pkg::STAT_EMPTY;
                            end else begin
                                stack_op.pop  = 1'b1;
                                count_next    = count_reg - CNT_W'(1);
                                out_addr_next = AW'(top_data);
                                used_next     = used_inc;
                                peak_next     = peak_cand;
                            end
                        end
                        fcpa_pkg::CMD_FREE: begin
                            if (count_reg == CNT_FULL) begin
                                out_stat_next = fcpa_pkg::STAT_FULL;
                            end else begin
                                stack_op.push = 1'b1;
                                push_data     = s_release_address[CELL_W-1:0];
                                count_next    = count_reg + CNT_W'(1);
                                used_next     = used_dec;
                            end
                        end
                        fcpa_pkg::CMD_RESET: begin
                            // result follows the refill
                            out_valid_next  = 1'b0;
                            state_next      = fcpa_pkg::ST_FILL;
                            fill_addr_next  = base_address_reg[CELL_W-1:0];
                            fill_step_next  = chunk_bytes_reg;
                            fill_cnt_next   = '0;
                            pend_reply_next = 1'b1;
                            count_next      = '0;
                            used_next       = '0;
                            peak_next       = '0;
                        end
                        default: begin
                        end
                    endcase
                    out_used_next = used_next;
                    out_peak_next = peak_next;
                end
            end
            default: begin
                state_next = fcpa_pkg::ST_RUN;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= fcpa_pkg::ST_FILL;
            fill_addr_reg  <= fcpa_pkg::BASE_ADDRESS_RST[CELL_W-1:0];
            fill_step_reg  <= fcpa_pkg::CHUNK_BYTES_RST;
            fill_cnt_reg   <= '0;
            pend_reply_reg <= 1'b0;
            count_reg      <= '0;
            used_reg       <= '0;
            peak_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            fill_addr_reg  <= fill_addr_next;
            fill_step_reg  <= fill_step_next;
            fill_cnt_reg   <= fill_cnt_next;
            pend_reply_reg <= pend_reply_next;
            count_reg      <= count_next;
            used_reg       <= used_next;
            peak_reg       <= peak_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        out_addr_reg <= out_addr_next;
        out_stat_reg <= out_stat_next;
        out_used_reg <= out_used_next;
        out_peak_reg <= out_peak_next;
    end

    assign m_valid         = out_valid_reg;
    assign m_chunk_address = out_addr_reg;
    assign m_status        = out_stat_reg;
    assign m_bytes_in_use  = out_used_reg;
    assign m_peak_bytes    = out_peak_reg;

    // Checks
    `FCPA_ASSERT_NOW(a_count_bound, aclk, aresetn, 1'b1, count_reg <= CNT_FULL,
        "free count above pool size")
    `FCPA_ASSERT_NOW(a_peak_covers_used, aclk, aresetn, 1'b1, peak_reg >= used_reg,
        "peak below bytes in use")
    `FCPA_ASSERT_NOW(a_addr_only_on_ok, aclk, aresetn,
        m_valid && (m_status != fcpa_pkg::STAT_OK), m_chunk_address == '0,
        "address given on a failed request")
    `FCPA_ASSERT_NEXT(a_fill_done, aclk, aresetn,
        (state_reg == fcpa_pkg::ST_FILL) && (fill_cnt_reg == FILL_LAST),
        (state_reg == fcpa_pkg::ST_RUN) && (count_reg == CNT_FULL),
        "refill did not end with a full stack")
    `FCPA_ASSERT_NEXT(a_pop_result, aclk, aresetn,
        stack_op.pop, m_valid && (m_chunk_address == AW'($past(top_data)))
        && (count_reg == $past(count_reg) - CNT_W'(1)),
        "allocate result does not match the popped cell")

endmodule

`default_nettype wire

>>> hdl/fcpa_cell.sv
// One stack cell: holds one free chunk address and shifts with its neighbors.
`default_nettype none

module fcpa_cell #(
    parameter int DATA_W = 32
) (
    input  wire logic              aclk,
    input  wire fcpa_pkg::stack_op_t op,
    input  wire logic [DATA_W-1:0] from_above,
    input  wire logic [DATA_W-1:0] from_below,
    output logic      [DATA_W-1:0] value
);

    logic [DATA_W-1:0] value_reg;
    logic [DATA_W-1:0] value_next;

    // push moves entries away from the top, pop moves them toward it
    always_comb begin
        value_next = value_reg;
        if (op.push) begin
            value_next = from_above;
        end else if (op.pop) begin
            value_next = from_below;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

`default_nettype wire

>>> hdl/fcpa_stack.sv
// Free-address stack built as a row of shifting cells, top in cell zero.
`default_nettype none

module fcpa_stack #(
    parameter int DEPTH  = fcpa_pkg::NUM_CHUNKS_DEF,
    parameter int DATA_W = 32
) (
    input  wire logic                aclk,
    input  wire fcpa_pkg::stack_op_t op,
    input  wire logic [DATA_W-1:0]   push_data,
    output logic      [DATA_W-1:0]   top_data
);

    logic [DATA_W-1:0] cell_val [DEPTH];

    // Cell i sees cell i-1 above and cell i+1 below
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [DATA_W-1:0] above;
        logic [DATA_W-1:0] below;

        if (i == 0) begin : g_first
            assign above = push_data;
        end else begin : g_mid_above
            assign above = cell_val[i-1];
        end

        if (i == DEPTH - 1) begin : g_last
            assign below = '0;
        end else begin : g_mid_below
            assign below = cell_val[i+1];
        end

        fcpa_cell #(
            .DATA_W(DATA_W)
        ) u_cell (
            .aclk      (aclk),
            .op        (op),
            .from_above(above),
            .from_below(below),
            .value     (cell_val[i])
        );
    end

    assign top_data = cell_val[0];

endmodule

`default_nettype wire
